// ----- design/lks_pkg.sv -----
package lks_pkg;

  localparam int KEY_W = 64;
  localparam int CAP_W = 7;
  localparam int OCC_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- design/lks_cell.sv -----
module lks_cell (
  input  logic               clk,
  input  logic               rst,
  input  lks_pkg::cell_ctrl_t ctrl,
  input  lks_pkg::key_t      cmp_key,
  input  lks_pkg::key_t      in_key,
  input  logic               in_valid,
  output lks_pkg::key_t      slot_key,
  output logic               slot_valid,
  output logic               match
);
  import lks_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      slot_key <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      slot_valid <= 1'b0;
    end else if (ctrl.shift) begin
      slot_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.capture) begin
      match <= slot_valid && (slot_key == cmp_key);
    end
  end

endmodule

// ----- design/lks_locate.sv -----
module lks_locate #(
  parameter int ENTRIES = 64,
  parameter int IW = 6
) (
  input  logic [ENTRIES-1:0] match,
  output logic               found,
  output logic [IW-1:0]      pos
);
  import lks_pkg::*;

  always_comb begin
    pos = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        pos = pos | IW'(i);
      end
    end
  end

  assign found = |match;

endmodule

// ----- design/lru_key_set.sv -----
// Recency-ordered set of 64-bit keys, used as a duplicate filter.
// Command channel: an item (command, key) is taken at a rising edge where
// start is high and busy is low. A lookup (command 0) only reports whether
// the key is held; an insert (command 1) refreshes a held key to the front
// or adds it at the front, dropping the oldest key when the store is full.
// The key is compared in every cell at the accepting edge; busy is then high
// while the row of cells shifts, and the result (hit and occupancy) is
// registered onto the result ports by that shift edge, with done high for one
// cycle. busy is low again in that cycle, so a new item can be taken while
// the result is shown, but not while the cell row is still shifting for the
// last one. The receiver cannot stall; each result beat is taken in the cycle
// it is shown.
// Configuration: a write beat on cfg_valid/cfg_ready loads the capacity and
// empties the store at once. cfg_ready is always high. Capacities above
// ENTRIES act as ENTRIES.
// Reset sets the capacity to 64, empties the store and clears busy and done.
module lru_key_set #(
  parameter int ENTRIES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command,
  input  lks_pkg::key_t                key,
  output logic                         done,
  output logic                         hit,
  output logic [lks_pkg::OCC_W-1:0]    occupancy,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lks_pkg::CAP_W-1:0]    cfg_data
);
  import lks_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int WW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [WW-1:0] ENTRIES_W = WW'(ENTRIES);

  logic [CAP_W-1:0]   capacity;
  logic [CW-1:0]      held;
  logic [CW-1:0]      held_next;
  logic               cmd_q;
  key_t               key_q;
  logic               cfg_write;
  logic               accept;
  logic [WW-1:0]      cap_ext;
  logic [CW-1:0]      eff_cap;
  logic [CW-1:0]      miss_slot;
  logic [IW-1:0]      bound;
  logic [IW-1:0]      hit_pos;
  logic               found;
  logic               shift_all;
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] valid_vec;
  key_t               key_vec [ENTRIES];

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign accept    = start && !busy;

  assign cap_ext = WW'(capacity);
  assign eff_cap = (cap_ext < ENTRIES_W) ? CW'(cap_ext) : CW'(ENTRIES_W);

  assign miss_slot = (held >= eff_cap) ? (eff_cap - CW'(1)) : held;
  assign bound     = found ? hit_pos : miss_slot[IW-1:0];
  assign shift_all = busy && cmd_q && (found || (eff_cap != '0));

  always_comb begin
    held_next = held;
    if (busy && cmd_q && !found && (eff_cap != '0)) begin
      held_next = miss_slot + CW'(1);
    end
  end

  lks_locate #(
    .ENTRIES(ENTRIES),
    .IW(IW)
  ) u_locate (
    .match(match_vec),
    .found(found),
    .pos(hit_pos)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    cell_ctrl_t ctrl;
    key_t       in_key;
    logic       in_valid;

    assign ctrl.clear   = cfg_write;
    assign ctrl.capture = accept;
    assign ctrl.shift   = shift_all && (IW'(i) <= bound);

    if (i == 0) begin : g_head
      assign in_key   = key_q;
      assign in_valid = 1'b1;
    end else begin : g_body
      assign in_key   = key_vec[i-1];
      assign in_valid = valid_vec[i-1];
    end

    lks_cell u_cell (
      .clk(clk),
      .rst(rst),
      .ctrl(ctrl),
      .cmp_key(key),
      .in_key(in_key),
      .in_valid(in_valid),
      .slot_key(key_vec[i]),
      .slot_valid(valid_vec[i]),
      .match(match_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      key_q <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      capacity <= CAP_RESET;
      held     <= '0;
    end else begin
      busy <= accept;
      done <= busy;
      if (cfg_write) begin
        capacity <= cfg_data;
        held     <= '0;
      end else begin
        held <= held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      hit       <= found;
      occupancy <= OCC_W'(held_next);
    end
  end

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk) disable iff (rst) busy |=> done)
    else $error("result beat missing after the shift cycle");

  a_single_shift: assert property (@(posedge clk) disable iff (rst) busy |=> !busy)
    else $error("shift cycle lasted more than one cycle");

  a_held_bound: assert property (@(posedge clk) disable iff (rst) held <= eff_cap)
    else $error("occupancy exceeds the effective capacity");

  a_unique_match: assert property (@(posedge clk) disable iff (rst)
      busy |-> $onehot0(match_vec))
    else $error("key held in more than one cell");

  a_prefix_valid: assert property (@(posedge clk) disable iff (rst)
      done |-> ($countones(valid_vec) == int'(held)))
    else $error("valid cells disagree with the occupancy count");
`endif

endmodule
